// ----- design/shuffled_pair_tournament_select_core_assert.svh -----
// Assertion helpers for the tournament select core.
`ifndef SHUFFLED_PAIR_TOURNAMENT_SELECT_CORE_ASSERT_SVH
`define SHUFFLED_PAIR_TOURNAMENT_SELECT_CORE_ASSERT_SVH

// Clocked check on clk_i, off while rst_ni is low.
`define SPTS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("spts check failed");

// Same, with a caller message.
`define SPTS_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

`endif

// ----- design/spts_pkg.sv -----
package spts_pkg;

  localparam logic [1:0] ACT_WR_FIT  = 2'd0;
  localparam logic [1:0] ACT_WR_KEY  = 2'd1;
  localparam logic [1:0] ACT_SHUFFLE = 2'd2;
  localparam logic [1:0] ACT_SELECT  = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_RESHUF   = 2'd1;
  localparam logic [1:0] ST_BAD_IDX  = 2'd2;

  localparam int unsigned POP_CNT_W  = 9;

  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_res_t;

endpackage

// ----- design/spts_cmp.sv -----
module spts_cmp #(
  parameter int unsigned W = 32
) (
  input  logic [W-1:0]       a_i,
  input  logic [W-1:0]       b_i,
  output spts_pkg::cmp_res_t res_o
);
  import spts_pkg::*;

  assign res_o.lt = (a_i < b_i);
  assign res_o.eq = (a_i == b_i);

endmodule

// ----- design/shuffled_pair_tournament_select_core.sv -----
// Writes and refused selects go straight from the input to the finish state.
// A select makes two order reads, two fitness reads and one shared compare; a
// shuffle makes one rank-count sweep over all keys per index, for n live individuals.
// One item at a time: the next input is taken once the result is in the output register.
// Output stalls hold the result; a next result waits in the finish state, blocking the input.
// rst_ni (async, active low): order invalid, pick 0, count 256; tables not cleared.
module shuffled_pair_tournament_select_core #(
  parameter int unsigned POP_MAX      = 256,
  parameter int unsigned FITNESS_BITS = 32,
  parameter int unsigned KEY_BITS     = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [8:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         action_i,
  input  logic [7:0]         index_i,
  input  logic signed [31:0] fitness_value_i,
  input  logic [31:0]        random_key_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic [7:0]         chosen_o,
  output logic [7:0]         loser_o
);
  import spts_pkg::*;

  localparam int unsigned AW    = (POP_MAX > 1) ? $clog2(POP_MAX) : 1;
  localparam int unsigned CW    = $clog2(POP_MAX + 1);
  localparam int unsigned NW    = (CW > POP_CNT_W) ? CW : POP_CNT_W;
  localparam int unsigned CMP_W = (FITNESS_BITS > KEY_BITS) ? FITNESS_BITS : KEY_BITS;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SA   = 4'd1;
  localparam logic [3:0] S_SB   = 4'd2;
  localparam logic [3:0] S_SC   = 4'd3;
  localparam logic [3:0] S_SD   = 4'd4;
  localparam logic [3:0] S_SE   = 4'd5;
  localparam logic [3:0] S_SHI  = 4'd6;
  localparam logic [3:0] S_SHK  = 4'd7;
  localparam logic [3:0] S_SHM  = 4'd8;
  localparam logic [3:0] S_SHW  = 4'd9;
  localparam logic [3:0] S_FIN  = 4'd10;

  logic [FITNESS_BITS-1:0] fit_mem [POP_MAX];
  logic [KEY_BITS-1:0]     key_mem [POP_MAX];
  logic [AW-1:0]           ord_mem [POP_MAX];

  logic [FITNESS_BITS-1:0] fit_rd_q;
  logic [KEY_BITS-1:0]     key_rd_q;
  logic [AW-1:0]           ord_rd_q;
  logic [AW-1:0]           fit_raddr, key_raddr, ord_raddr;

  logic [3:0]              state_q, state_d;
  logic [POP_CNT_W-1:0]    pop_q;
  logic                    ovalid_q, ovalid_d;
  logic [CW-1:0]           pick_q, pick_d;
  logic [CW-1:0]           i_q, i_d;
  logic [CW-1:0]           m_q, m_d;
  logic [CW-1:0]           pm_q, pm_d;
  logic                    pv_q, pv_d;
  logic [CW-1:0]           rank_q, rank_d;
  logic [KEY_BITS-1:0]     ki_q, ki_d;
  logic [AW-1:0]           a_q, a_d, b_q, b_d;
  logic [FITNESS_BITS-1:0] fa_q, fa_d;
  logic [1:0]              rs_q, rs_d;
  logic [7:0]              rc_q, rc_d, rl_q, rl_d;
  logic                    out_valid_q, out_valid_d;
  logic [1:0]              status_q, status_d;
  logic [7:0]              chosen_q, chosen_d, loser_q, loser_d;

  logic [NW-1:0]           pop_ext, n_ext, idx_ext;
  logic [CW-1:0]           n;
  logic                    in_xfer, idx_ok;
  logic [CW:0]             pick_nx;
  logic [CMP_W-1:0]        cmp_a, cmp_b;
  cmp_res_t                cmp_res;

  assign pop_ext = NW'(pop_q);
  always_comb begin
    priority if (pop_ext < NW'(2)) begin
      n_ext = NW'(2);
    end else if (pop_ext > NW'(POP_MAX)) begin
      n_ext = NW'(POP_MAX);
    end else begin
      n_ext = pop_ext;
    end
  end
  assign n       = n_ext[CW-1:0];
  assign idx_ext = NW'(index_i);
  assign idx_ok  = idx_ext < n_ext;
  assign in_xfer = in_valid_i && in_ready_o;
  assign pick_nx = {1'b0, pick_q} + (CW+1)'(1);

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign chosen_o    = chosen_q;
  assign loser_o     = loser_q;

  always_comb begin
    cmp_a = CMP_W'(key_rd_q);
    cmp_b = CMP_W'(ki_q);
    if (state_q == S_SE) begin
      cmp_a = CMP_W'({~fit_rd_q[FITNESS_BITS-1], fit_rd_q[FITNESS_BITS-2:0]});
      cmp_b = CMP_W'({~fa_q[FITNESS_BITS-1], fa_q[FITNESS_BITS-2:0]});
    end
  end

  spts_cmp #(.W(CMP_W)) u_cmp (
    .a_i   (cmp_a),
    .b_i   (cmp_b),
    .res_o (cmp_res)
  );

  assign fit_raddr = (state_q == S_SC) ? a_q : b_q;
  assign key_raddr = (state_q == S_SHM) ? m_q[AW-1:0] : i_q[AW-1:0];
  assign ord_raddr = (state_q == S_SB) ? pick_nx[AW-1:0] : pick_q[AW-1:0];

  always_ff @(posedge clk_i) begin
    fit_rd_q <= fit_mem[fit_raddr];
    key_rd_q <= key_mem[key_raddr];
    ord_rd_q <= ord_mem[ord_raddr];
    if (in_xfer && idx_ok && action_i == ACT_WR_FIT) begin
      fit_mem[idx_ext[AW-1:0]] <= FITNESS_BITS'(fitness_value_i);
    end
    if (in_xfer && idx_ok && action_i == ACT_WR_KEY) begin
      key_mem[idx_ext[AW-1:0]] <= KEY_BITS'(random_key_i);
    end
    if (state_q == S_SHW) begin
      ord_mem[rank_q[AW-1:0]] <= i_q[AW-1:0];
    end
  end

  always_comb begin
    state_d     = state_q;
    ovalid_d    = ovalid_q;
    pick_d      = pick_q;
    i_d         = i_q;
    m_d         = m_q;
    pm_d        = pm_q;
    pv_d        = pv_q;
    rank_d      = rank_q;
    ki_d        = ki_q;
    a_d         = a_q;
    b_d         = b_q;
    fa_d        = fa_q;
    rs_d        = rs_q;
    rc_d        = rc_q;
    rl_d        = rl_q;
    out_valid_d = out_valid_q;
    status_d    = status_q;
    chosen_d    = chosen_q;
    loser_d     = loser_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          rs_d  = ST_OK;
          rc_d  = '0;
          rl_d  = '0;
          unique case (action_i)
            ACT_WR_FIT, ACT_WR_KEY: begin
              if (!idx_ok) begin
                rs_d = ST_BAD_IDX;
              end
              state_d = S_FIN;
            end
            ACT_SHUFFLE: begin
              i_d     = '0;
              state_d = S_SHI;
            end
            default: begin
              if (!ovalid_q || pick_nx >= {1'b0, n}) begin
                rs_d    = ST_RESHUF;
                state_d = S_FIN;
              end else begin
                state_d = S_SA;
              end
            end
          endcase
        end
      end
      S_SA: state_d = S_SB;
      S_SB: begin
        a_d     = ord_rd_q;
        state_d = S_SC;
      end
      S_SC: begin
        b_d     = ord_rd_q;
        state_d = S_SD;
      end
      S_SD: begin
        fa_d    = fit_rd_q;
        state_d = S_SE;
      end
      S_SE: begin
        if (cmp_res.lt) begin
          rc_d = 8'(b_q);
          rl_d = 8'(a_q);
        end else begin
          rc_d = 8'(a_q);
          rl_d = 8'(b_q);
        end
        pick_d  = pick_q + CW'(2);
        state_d = S_FIN;
      end
      S_SHI: state_d = S_SHK;
      S_SHK: begin
        ki_d    = key_rd_q;
        rank_d  = '0;
        m_d     = '0;
        pv_d    = 1'b0;
        state_d = S_SHM;
      end
      S_SHM: begin
        if (pv_q && (cmp_res.lt || (cmp_res.eq && pm_q < i_q))) begin
          rank_d = rank_q + CW'(1);
        end
        if (m_q < n) begin
          pm_d = m_q;
          m_d  = m_q + CW'(1);
          pv_d = 1'b1;
        end else begin
          pv_d = 1'b0;
          if (!pv_q) begin
            state_d = S_SHW;
          end
        end
      end
      S_SHW: begin
        i_d = i_q + CW'(1);
        if (i_q + CW'(1) == n) begin
          pick_d   = '0;
          ovalid_d = 1'b1;
          state_d  = S_FIN;
        end else begin
          state_d = S_SHI;
        end
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          status_d    = rs_q;
          chosen_d    = rc_q;
          loser_d     = rl_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (cfg_valid_i) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pop_q       <= POP_CNT_W'(256);
      ovalid_q    <= 1'b0;
      pick_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ovalid_q    <= ovalid_d;
      pick_q      <= pick_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        pop_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    i_q      <= i_d;
    m_q      <= m_d;
    pm_q     <= pm_d;
    pv_q     <= pv_d;
    rank_q   <= rank_d;
    ki_q     <= ki_d;
    a_q      <= a_d;
    b_q      <= b_d;
    fa_q     <= fa_d;
    rs_q     <= rs_d;
    rc_q     <= rc_d;
    rl_q     <= rl_d;
    status_q <= status_d;
    chosen_q <= chosen_d;
    loser_q  <= loser_d;
  end

`include "shuffled_pair_tournament_select_core_assert.svh"

  `SPTS_ASSERT(a_busy_after_xfer, in_valid_i && in_ready_o |=> !in_ready_o)
  `SPTS_ASSERT(a_pick_even, !pick_q[0])
  `SPTS_ASSERT_MSG(a_order_drop_cfg, $fell(ovalid_q) |-> $past(cfg_valid_i),
                   "order dropped without count write")
  `SPTS_ASSERT_MSG(a_fin_only_result, $rose(out_valid_q) |-> $past(state_q) == S_FIN,
                   "result not from finish state")

endmodule

// ----- verif/shuffled_pair_tournament_select_core_tb.sv -----
`timescale 1ns / 100ps

module shuffled_pair_tournament_select_core_tb;
  import spts_pkg::*;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] chosen;
    logic [7:0] loser;
  } pick_t;

  class tourney_board;
    logic signed [31:0] fit_tab [256];
    logic [31:0]        key_tab [256];
    logic [7:0]         ord_tab [256];
    int                 pick_ptr;
    bit                 ord_ok;
    int                 live_n;
    pick_t              awaited [$];
    int                 errors;

    function new();
      pick_ptr = 0;
      ord_ok   = 0;
      live_n   = 256;
      errors   = 0;
    endfunction

    function void set_count(logic [8:0] v);
      live_n = (v < 2) ? 2 : (v > 256) ? 256 : int'(v);
      ord_ok = 0;
    endfunction

    function void reorder();
      int j;
      logic [7:0] cur;
      for (int i = 0; i < live_n; i++) begin
        cur = i[7:0];
        j = i;
        while (j > 0 && key_tab[ord_tab[j-1]] > key_tab[cur]) begin
          ord_tab[j] = ord_tab[j-1];
          j--;
        end
        ord_tab[j] = cur;
      end
      pick_ptr = 0;
      ord_ok = 1;
    endfunction

    function void note_input(logic [1:0] a, logic [7:0] ix, logic [31:0] f, logic [31:0] k);
      pick_t r;
      logic [7:0] pa, pb;
      r = '0;
      if (a == ACT_WR_FIT || a == ACT_WR_KEY) begin
        if (ix >= live_n) r.status = ST_BAD_IDX;
        else if (a == ACT_WR_FIT) fit_tab[ix] = f;
        else key_tab[ix] = k;
      end else if (a == ACT_SHUFFLE) begin
        reorder();
      end else begin
        if (!ord_ok || pick_ptr + 1 >= live_n) begin
          r.status = ST_RESHUF;
        end else begin
          pa = ord_tab[pick_ptr];
          pb = ord_tab[pick_ptr+1];
          pick_ptr += 2;
          if (fit_tab[pa] <= fit_tab[pb]) begin
            r.chosen = pa;
            r.loser = pb;
          end else begin
            r.chosen = pb;
            r.loser = pa;
          end
        end
      end
      awaited.push_back(r);
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task check(pick_t got);
      pick_t w;
      if (awaited.size() == 0) begin
        report($sformatf("unexpected result %p", got));
        return;
      end
      w = awaited.pop_front();
      if (got.status !== w.status)
        report($sformatf("status got %0d want %0d", got.status, w.status));
      if (got.chosen !== w.chosen)
        report($sformatf("chosen got %0d want %0d", got.chosen, w.chosen));
      if (got.loser !== w.loser)
        report($sformatf("loser got %0d want %0d", got.loser, w.loser));
    endtask
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic cfg_valid_i = 0;
  logic cfg_ready_o;
  logic [8:0] cfg_data_i = '0;
  logic in_valid_i = 0;
  logic in_ready_o;
  logic [1:0] action_i = '0;
  logic [7:0] index_i = '0;
  logic signed [31:0] fitness_value_i = '0;
  logic [31:0] random_key_i = '0;
  logic out_valid_o;
  logic out_ready_i = 0;
  logic [1:0] status_o;
  logic [7:0] chosen_o;
  logic [7:0] loser_o;

  shuffled_pair_tournament_select_core dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .in_valid_i, .in_ready_o, .action_i, .index_i, .fitness_value_i, .random_key_i,
    .out_valid_o, .out_ready_i, .status_o, .chosen_o, .loser_o
  );

  tourney_board sb = new();
  bit calm = 0;
  bit hold_req = 0;
  bit fit_set [256];
  bit key_set [256];
  int cur_n = 256;
  int sent = 0;
  longint cycles = 0;

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 2000000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk_i)
    if (rst_ni && out_valid_o && out_ready_i) sb.check({status_o, chosen_o, loser_o});

  initial begin
    @(posedge rst_ni);
    out_ready_i <= 1;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready_i <= 0;
        repeat (400) @(posedge clk_i);
        out_ready_i <= 1;
        hold_req = 0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_ready_i <= 0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
        out_ready_i <= 1;
      end
    end
  end

  task automatic push_item(logic [1:0] a, logic [7:0] ix, logic [31:0] f, logic [31:0] k);
    if (!calm && $urandom_range(0, 9) == 0) begin
      in_valid_i <= 0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    in_valid_i <= 1;
    action_i <= a;
    index_i <= ix;
    fitness_value_i <= f;
    random_key_i <= k;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(a, ix, f, k);
    if (ix < cur_n && a == ACT_WR_FIT) fit_set[ix] = 1;
    if (ix < cur_n && a == ACT_WR_KEY) key_set[ix] = 1;
    sent++;
  endtask

  task automatic settle();
    in_valid_i <= 0;
    while (sb.awaited.size() > 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_count(logic [8:0] v);
    settle();
    cfg_valid_i <= 1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 0;
    sb.set_count(v);
    cur_n = (v < 2) ? 2 : (v > 256) ? 256 : int'(v);
  endtask

  function automatic logic [31:0] rand_fit();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2, 3: return 32'($signed($urandom_range(0, 6)) - 3);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] rand_key();
    case ($urandom_range(0, 5))
      0: return 32'hFFFF_FFFF;
      1: return 32'h0;
      2, 3: return $urandom_range(0, 3);
      default: return $urandom();
    endcase
  endfunction

  task automatic run_phase(logic [8:0] cnt, int items);
    int missing;
    int r;
    bit shuffled;
    logic [7:0] ix;
    write_count(cnt);
    shuffled = 0;
    for (int it = 0; it < items; it++) begin
      missing = -1;
      for (int i = cur_n - 1; i >= 0; i--)
        if (!fit_set[i] || !key_set[i]) missing = i;
      r = $urandom_range(0, 99);
      ix = ($urandom_range(0, 4) == 0) ? 8'($urandom()) : 8'($urandom_range(0, cur_n - 1));
      if (sent == 300) hold_req = 1;
      if (sent == 600) settle();
      if (r < 15) push_item(ACT_WR_FIT, ix, rand_fit(), $urandom());
      else if (r < 25) push_item(ACT_WR_KEY, ix, $urandom(), rand_key());
      else if (missing >= 0) begin
        if (!fit_set[missing]) push_item(ACT_WR_FIT, 8'(missing), rand_fit(), $urandom());
        else push_item(ACT_WR_KEY, 8'(missing), $urandom(), rand_key());
      end else if (r < 35 && (cur_n <= 32 || !shuffled)) begin
        push_item(ACT_SHUFFLE, 8'($urandom()), $urandom(), $urandom());
        shuffled = 1;
      end else push_item(ACT_SELECT, 8'($urandom()), $urandom(), $urandom());
    end
  endtask

  initial begin
    logic [8:0] plan [8] = '{9'd1, 9'd17, 9'd256, 9'd5, 9'd511, 9'd2, 9'd9, 9'd4};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    push_item(ACT_SELECT, 8'd0, 32'd0, 32'd0);
    write_count(9'd0);
    push_item(ACT_WR_FIT, 8'd0, 32'h8000_0000, 32'd0);
    push_item(ACT_WR_FIT, 8'd1, 32'h7FFF_FFFF, 32'd0);
    push_item(ACT_WR_KEY, 8'd0, 32'd0, 32'hFFFF_FFFF);
    push_item(ACT_WR_KEY, 8'd1, 32'hFFFF_FFFF, 32'h0);
    push_item(ACT_WR_FIT, 8'd2, 32'd5, 32'd0);
    push_item(ACT_WR_KEY, 8'd255, 32'd0, 32'd7);
    push_item(ACT_SELECT, 8'd0, 32'd0, 32'd0);
    push_item(ACT_SHUFFLE, 8'd0, 32'd0, 32'd0);
    push_item(ACT_SELECT, 8'd0, 32'd0, 32'd0);
    push_item(ACT_SELECT, 8'd0, 32'd0, 32'd0);
    push_item(ACT_WR_FIT, 8'd1, 32'h8000_0000, 32'd0);
    push_item(ACT_WR_KEY, 8'd1, 32'd0, 32'hFFFF_FFFF);
    push_item(ACT_SHUFFLE, 8'd0, 32'd0, 32'd0);
    push_item(ACT_SELECT, 8'd0, 32'd0, 32'd0);
    write_count(9'd3);
    push_item(ACT_WR_FIT, 8'd2, 32'd0, 32'd0);
    push_item(ACT_WR_KEY, 8'd2, 32'd0, 32'd0);
    push_item(ACT_SELECT, 8'd0, 32'd0, 32'd0);
    push_item(ACT_SHUFFLE, 8'd0, 32'd0, 32'd0);
    push_item(ACT_SELECT, 8'd0, 32'd0, 32'd0);
    push_item(ACT_SELECT, 8'd0, 32'd0, 32'd0);

    foreach (plan[p])
      run_phase(plan[p], (plan[p] > 9'd32) ? 150 : 60);
    while (sent < 1150) begin
      if (sent > 1000) calm = 1;
      run_phase(9'($urandom_range(2, 24)), $urandom_range(40, 90));
    end

    settle();
    repeat (50) @(posedge clk_i);
    if (sb.errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule

// ----- files.f -----
+incdir+design
design/spts_pkg.sv
design/spts_cmp.sv
design/shuffled_pair_tournament_select_core.sv
verif/shuffled_pair_tournament_select_core_tb.sv
